FILE: hdl/chi_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the capped h-index core estimate block.
// Used by chi_ctrl, chi_hist_mem and the top level; depends on nothing.
package chi_pkg;

    localparam int OWN_W          = 11;
    localparam int NB_W           = 16;
    localparam int BIN_W          = 11;
    localparam int ACC_W          = 12;
    localparam int NUM_BINS_DEF   = 1024;

    localparam logic [BIN_W-1:0] BIN_SAT = {BIN_W{1'b1}};

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_UPD,
        ST_SCAN_RD,
        ST_SCAN_ACC,
        ST_CLR
    } t_state;

    // Port controls of the histogram memory.
    typedef struct packed {
        logic rd;
        logic wr;
    } t_mem_ctl;

    // A finished result handed to the output register.
    typedef struct packed {
        logic             push;
        logic [OWN_W-1:0] value;
    } t_res;

endpackage

FILE: hdl/capped_h_index_core_estimate.sv
`timescale 1ns / 1ps
// An item without last is taken in ST_IDLE; a counted neighbor then stalls the input
// in ST_UPD while its bin is written back. After any update, a last item has each bin
// from the own estimate E down to the answer k read and cleared in ST_SCAN_RD and
// summed in ST_SCAN_ACC; ST_CLR then clears the bins below k. The single-port histogram
// memory and its read-modify-write set this sequence. Reset (synchronous, active low)
// sweeps all NUM_BINS bins to zero; no item is accepted until the sweep ends.
module capped_h_index_core_estimate
    import chi_pkg::*;
#(
    parameter int NUM_BINS = NUM_BINS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [OWN_W-1:0]  i_own_estimate,
    input  logic [NB_W-1:0]   i_neighbor_estimate,
    input  logic              i_neighbor_valid,
    input  logic              i_last,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [OWN_W-1:0]  o_new_estimate
);

    // The histogram holds one bin per possible clipped estimate.
    localparam int AW = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;

    t_res              w_res;
    t_mem_ctl          w_mem_ctl;
    logic [AW-1:0]     w_mem_addr;
    logic [BIN_W-1:0]  w_mem_wdata;
    logic [BIN_W-1:0]  w_mem_rdata;
    logic              w_slot_free;

    logic              r_out_valid;
    logic [OWN_W-1:0]  r_out_value;

    // The sequencer owns the memory port and the shared accumulate-and-compare step.
    chi_ctrl #(
        .NUM_BINS (NUM_BINS),
        .AW       (AW)
    ) u_ctrl (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_stall             (o_stall),
        .i_own_estimate      (i_own_estimate),
        .i_neighbor_estimate (i_neighbor_estimate),
        .i_neighbor_valid    (i_neighbor_valid),
        .i_last              (i_last),
        .i_slot_free         (w_slot_free),
        .o_res               (w_res),
        .o_mem_ctl           (w_mem_ctl),
        .o_mem_addr          (w_mem_addr),
        .o_mem_wdata         (w_mem_wdata),
        .i_mem_rdata         (w_mem_rdata)
    );

    chi_hist_mem #(
        .DEPTH (NUM_BINS),
        .AW    (AW),
        .W     (BIN_W)
    ) u_hist (
        .i_clk   (i_clk),
        .i_ctl   (w_mem_ctl),
        .i_addr  (w_mem_addr),
        .i_wdata (w_mem_wdata),
        .o_rdata (w_mem_rdata)
    );

    // The output register may take a new result when it is empty or being drained,
    // so the clearing sweep runs while the previous result waits downstream.
    assign w_slot_free = !r_out_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res.push) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res.push) begin
            r_out_value <= w_res.value;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_new_estimate = r_out_value;

endmodule

FILE: hdl/chi_hist_mem.sv
`timescale 1ns / 1ps
// Single-port histogram memory with registered read data.
// Depends on chi_pkg for the memory control struct.
module chi_hist_mem
    import chi_pkg::*;
#(
    parameter int DEPTH = NUM_BINS_DEF,
    parameter int AW    = 10,
    parameter int W     = BIN_W
) (
    input  logic          i_clk,
    input  t_mem_ctl      i_ctl,
    input  logic [AW-1:0] i_addr,
    input  logic [W-1:0]  i_wdata,
    output logic [W-1:0]  o_rdata
);

    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata;

    // Read returns the old contents when the same entry is written.
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_ctl.rd) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/chi_ctrl.sv
`timescale 1ns / 1ps
// Sequencer for histogram updates, the downward scan and the clearing sweeps.
// Depends on chi_pkg; drives the port of chi_hist_mem.
module chi_ctrl
    import chi_pkg::*;
#(
    parameter int NUM_BINS = NUM_BINS_DEF,
    parameter int AW       = 10
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [OWN_W-1:0]  i_own_estimate,
    input  logic [NB_W-1:0]   i_neighbor_estimate,
    input  logic              i_neighbor_valid,
    input  logic              i_last,
    input  logic              i_slot_free,
    output t_res              o_res,
    output t_mem_ctl          o_mem_ctl,
    output logic [AW-1:0]     o_mem_addr,
    output logic [BIN_W-1:0]  o_mem_wdata,
    input  logic [BIN_W-1:0]  i_mem_rdata
);

    t_state            r_state, n_state;
    logic [OWN_W-1:0]  r_held, n_held;
    logic              r_in_run, n_in_run;
    logic              r_last, n_last;
    logic [OWN_W-1:0]  r_k, n_k;
    logic [ACC_W-1:0]  r_acc, n_acc;
    logic [AW-1:0]     r_addr, n_addr;

    logic [OWN_W-1:0]  w_held_sel;
    logic [OWN_W-1:0]  w_bin;
    logic [OWN_W-1:0]  w_bin_idx;
    logic [AW-1:0]     w_bin_addr;
    logic [OWN_W-1:0]  w_k_dec;
    logic [ACC_W-1:0]  w_sum;

    // The own estimate is taken from the first item of a run and saturated.
    always_comb begin
        if (r_in_run) begin
            w_held_sel = r_held;
        end else if (17'(i_own_estimate) > 17'(NUM_BINS)) begin
            w_held_sel = OWN_W'(NUM_BINS);
        end else begin
            w_held_sel = i_own_estimate;
        end
    end

    // Unknown (zero) or larger neighbor estimates count at the own estimate.
    always_comb begin
        if (i_neighbor_estimate == '0 || i_neighbor_estimate > NB_W'(w_held_sel)) begin
            w_bin = w_held_sel;
        end else begin
            w_bin = i_neighbor_estimate[OWN_W-1:0];
        end
    end

    assign w_bin_idx  = OWN_W'(w_bin - 1'b1);
    assign w_bin_addr = AW'(w_bin_idx);
    assign w_k_dec    = OWN_W'(r_k - 1'b1);
    assign w_sum      = r_acc + ACC_W'(i_mem_rdata);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_INIT;
            r_in_run <= 1'b0;
            r_held   <= '0;
            r_addr   <= '0;
        end else begin
            r_state  <= n_state;
            r_in_run <= n_in_run;
            r_held   <= n_held;
            r_addr   <= n_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_last <= n_last;
        r_k    <= n_k;
        r_acc  <= n_acc;
    end

    always_comb begin
        n_state     = r_state;
        n_held      = r_held;
        n_in_run    = r_in_run;
        n_last      = r_last;
        n_k         = r_k;
        n_acc       = r_acc;
        n_addr      = r_addr;
        o_stall     = 1'b1;
        o_res       = '0;
        o_mem_ctl   = '0;
        o_mem_addr  = '0;
        o_mem_wdata = '0;
        case (r_state)
            ST_INIT: begin
                o_mem_ctl.wr = 1'b1;
                o_mem_addr   = r_addr;
                if (r_addr == AW'(NUM_BINS - 1)) begin
                    n_addr  = '0;
                    n_state = ST_IDLE;
                end else begin
                    n_addr = AW'(r_addr + 1'b1);
                end
            end
            ST_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    n_held   = w_held_sel;
                    n_in_run = !i_last;
                    n_last   = i_last;
                    n_k      = w_held_sel;
                    n_acc    = '0;
                    if (i_neighbor_valid && w_held_sel != '0) begin
                        o_mem_ctl.rd = 1'b1;
                        o_mem_addr   = w_bin_addr;
                        n_addr       = w_bin_addr;
                        n_state      = ST_UPD;
                    end else if (i_last) begin
                        n_state = ST_SCAN_RD;
                    end
                end
            end
            ST_UPD: begin
                o_mem_ctl.wr = 1'b1;
                o_mem_addr   = r_addr;
                o_mem_wdata  = (i_mem_rdata < BIN_SAT) ?
                               BIN_W'(i_mem_rdata + 1'b1) : i_mem_rdata;
                if (r_last) begin
                    n_k     = r_held;
                    n_acc   = '0;
                    n_state = ST_SCAN_RD;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_SCAN_RD: begin
                if (r_k == '0) begin
                    // Scan ran out: the result is zero and every bin is clear.
                    if (i_slot_free) begin
                        o_res.push = 1'b1;
                        n_state    = ST_IDLE;
                    end
                end else begin
                    // Read the bin and clear it in the same access.
                    o_mem_ctl.rd = 1'b1;
                    o_mem_ctl.wr = 1'b1;
                    o_mem_addr   = AW'(w_k_dec);
                    n_state      = ST_SCAN_ACC;
                end
            end
            ST_SCAN_ACC: begin
                if (w_sum >= ACC_W'(r_k)) begin
                    if (i_slot_free) begin
                        o_res.push  = 1'b1;
                        o_res.value = r_k;
                        n_k         = w_k_dec;
                        n_state     = ST_CLR;
                    end
                end else begin
                    n_acc   = w_sum;
                    n_k     = w_k_dec;
                    n_state = ST_SCAN_RD;
                end
            end
            ST_CLR: begin
                if (r_k == '0) begin
                    n_state = ST_IDLE;
                end else begin
                    o_mem_ctl.wr = 1'b1;
                    o_mem_addr   = AW'(w_k_dec);
                    n_k          = w_k_dec;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: hdl/chi_checker.sv
`timescale 1ns / 1ps
// Port-level checks for capped_h_index_core_estimate, bound to the top level.
// Depends on chi_pkg for field widths.
module chi_checker
    import chi_pkg::*;
#(
    parameter int NUM_BINS = NUM_BINS_DEF
) (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_valid,
    input logic              o_stall,
    input logic              i_last,
    input logic              o_valid,
    input logic              i_stall,
    input logic [OWN_W-1:0]  o_new_estimate
);

    // A result waiting on a stalled consumer stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result dropped while stalled");

    // No result ever exceeds NUM_BINS, the saturation bound of the own estimate.
    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (32'(o_new_estimate) <= NUM_BINS))
        else $error("result above maximum degree");

    // An item that does not close a run creates no result.
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && !i_last && !o_valid |=> !o_valid)
        else $error("result without a last item");

    // After the last item the block is busy scanning.
    a_busy_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && i_last |=> o_stall)
        else $error("new item taken during the scan");

    // Reset empties the output register.
    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind capped_h_index_core_estimate chi_checker #(
    .NUM_BINS (NUM_BINS)
) u_chi_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_stall        (o_stall),
    .i_last         (i_last),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_new_estimate (o_new_estimate)
);

FILE: test/chi_core_checker.sv
`timescale 1ns / 1ps
// Scoreboard for capped_h_index_core_estimate: mirrors the neighbor histogram and the
// end-of-run scan to predict every new estimate, then checks the results in order.
// Depends on chi_pkg for widths and the bin saturation value.
module chi_core_checker
    import chi_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_stall,
    input  logic [OWN_W-1:0] i_own_estimate,
    input  logic [NB_W-1:0]  i_neighbor_estimate,
    input  logic             i_neighbor_valid,
    input  logic             i_last,
    input  logic             i_out_valid,
    input  logic             i_out_stall,
    input  logic [OWN_W-1:0] i_new_estimate,
    output int               o_fail_count,
    output int               o_pending
);

    logic [BIN_W-1:0] nb_hist [NUM_BINS_DEF];
    logic [OWN_W-1:0] run_estimate;
    logic             run_open;
    logic [OWN_W-1:0] core_expect_q [$];
    int               fail_total = 0;

    assign o_fail_count = fail_total;

    function automatic logic [OWN_W-1:0] scan_core(input int own);
        int k;
        int acc;
        bit hit;
        k   = own;
        acc = 0;
        hit = 1'b0;
        while (k > 0 && !hit) begin
            acc += nb_hist[k-1];
            if (acc >= k) begin
                hit = 1'b1;
            end else begin
                k--;
            end
        end
        return OWN_W'(k);
    endfunction

    task automatic clear_hist();
        int i;
        for (i = 0; i < NUM_BINS_DEF; i++) begin
            nb_hist[i] = '0;
        end
    endtask

    // Updates the histogram for one accepted item and queues a result on a last item.
    task automatic absorb_item(input logic [OWN_W-1:0] own_in, input logic [NB_W-1:0] nb,
                               input logic nbv, input logic lst);
        int bin;
        if (!run_open) begin
            run_estimate = OWN_W'((own_in > NUM_BINS_DEF) ? NUM_BINS_DEF : own_in);
        end
        if (nbv && run_estimate != 0) begin
            bin = int'((nb == 0 || nb > run_estimate) ? NB_W'(run_estimate) : nb);
            if (nb_hist[bin-1] != BIN_SAT) begin
                nb_hist[bin-1] = nb_hist[bin-1] + 1'b1;
            end
        end
        if (lst) begin
            core_expect_q.push_back(scan_core(int'(run_estimate)));
            clear_hist();
            run_open = 1'b0;
        end else begin
            run_open = 1'b1;
        end
    endtask

    task automatic check_result(input logic [OWN_W-1:0] got);
        logic [OWN_W-1:0] want;
        if (core_expect_q.size() == 0) begin
            fail_total++;
            $display("%0t: new_estimate with none pending: expected none, actual %0d",
                     $time, got);
        end else begin
            want = core_expect_q.pop_front();
            if (got !== want) begin
                fail_total++;
                $display("%0t: new_estimate mismatch: expected %0d, actual %0d",
                         $time, want, got);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_hist();
            run_open     = 1'b0;
            run_estimate = '0;
            core_expect_q.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                check_result(i_new_estimate);
            end
            if (i_in_valid && !i_in_stall) begin
                absorb_item(i_own_estimate, i_neighbor_estimate, i_neighbor_valid, i_last);
            end
        end
        o_pending <= core_expect_q.size();
    end

endmodule

FILE: test/capped_h_index_core_estimate_tb.sv
`timescale 1ns / 1ps
// Top of the capped_h_index_core_estimate testbench: clock, reset, vertex-run stimulus,
// output stalls and the verdict. Depends on chi_pkg, the block and chi_core_checker.
module capped_h_index_core_estimate_tb;
    import chi_pkg::*;

    // Items in the whole run, and the point from which both sides stop idling.
    localparam int ITEM_GOAL    = 1100;
    localparam int QUIET_FROM   = 880;
    // The limit sits well above what the run would need even if every item closed a run
    // with a full-size scan plus idle and stall bursts.
    localparam int CYCLE_LIMIT  = 10_000_000;
    // After the last result the block may still clear up to NUM_BINS - 1 bins.
    localparam int DRAIN_CYCLES = 2 * NUM_BINS_DEF + 16;
    // Length of the run that piles its neighbors into a single bin.
    localparam int FLOOD_LEN    = 60;

    logic             i_clk               = 1'b0;
    logic             i_rst_n             = 1'b0;
    logic             i_valid             = 1'b0;
    logic [OWN_W-1:0] i_own_estimate      = '0;
    logic [NB_W-1:0]  i_neighbor_estimate = '0;
    logic             i_neighbor_valid    = 1'b0;
    logic             i_last              = 1'b0;
    logic             i_stall             = 1'b0;
    logic             o_stall;
    logic             o_valid;
    logic [OWN_W-1:0] o_new_estimate;

    int fail_count;
    int pending_count;
    int cycle_count     = 0;
    int items_sent      = 0;
    int stall_left      = 0;
    bit calm            = 1'b0;
    bit sender_gaps     = 1'b1;
    bit receiver_stalls = 1'b1;

    capped_h_index_core_estimate #(
        .NUM_BINS(NUM_BINS_DEF)
    ) dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_stall             (o_stall),
        .i_own_estimate      (i_own_estimate),
        .i_neighbor_estimate (i_neighbor_estimate),
        .i_neighbor_valid    (i_neighbor_valid),
        .i_last              (i_last),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_new_estimate      (o_new_estimate)
    );

    chi_core_checker core_check (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_valid),
        .i_in_stall          (o_stall),
        .i_own_estimate      (i_own_estimate),
        .i_neighbor_estimate (i_neighbor_estimate),
        .i_neighbor_valid    (i_neighbor_valid),
        .i_last              (i_last),
        .i_out_valid         (o_valid),
        .i_out_stall         (i_stall),
        .i_new_estimate      (o_new_estimate),
        .o_fail_count        (fail_count),
        .o_pending           (pending_count)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Cycle counter and the output-side stall pattern. Stalls come in random
    // bursts, and the stall behavior is re-rolled periodically so that long
    // stretches without any stall also occur. Once the run turns calm the
    // receiver never stalls again.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count % 200 == 0) begin
            receiver_stalls <= ($urandom_range(0, 3) != 0);
        end
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_stall    <= 1'b1;
        end else if (!calm && receiver_stalls && $urandom_range(0, 3) == 0) begin
            stall_left <= $urandom_range(0, 2);
            i_stall    <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // Watchdog: a hung handshake or a lost result ends here.
    initial begin
        while (cycle_count < CYCLE_LIMIT) @(posedge i_clk);
        $display("FAIL capped_h_index_core_estimate");
        $finish;
    end

    // Presents one item and holds it until the block takes it. An optional idle
    // burst goes in front of the item. Valid stays high from one item to the
    // next when there is no burst, so it is never lowered and raised in the
    // same time step.
    task automatic send_item(input logic [OWN_W-1:0] own, input logic [NB_W-1:0] nb,
                             input logic nbv, input logic lst);
        if (!calm && sender_gaps && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_valid             <= 1'b1;
        i_own_estimate      <= own;
        i_neighbor_estimate <= nb;
        i_neighbor_valid    <= nbv;
        i_last              <= lst;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        items_sent++;
    endtask

    // Neighbor estimates cluster around the clipping point so the scan has
    // something to find, with unknowns (zero) and the full 16-bit range mixed in.
    function automatic logic [NB_W-1:0] pick_neighbor(input int cap);
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 2) begin
            return '0;
        end else if (roll < 7) begin
            return NB_W'($urandom_range(1, cap + 2));
        end else if (roll == 7) begin
            return NB_W'(cap);
        end else begin
            return NB_W'($urandom_range(0, (1 << NB_W) - 1));
        end
    endfunction

    // Sends one vertex: the own estimate rides on the first item only; later
    // items carry random own values that the block must ignore. A run with no
    // neighbors is a single item with neighbor_valid low and last high.
    task automatic send_run(input logic [OWN_W-1:0] own, input int count);
        int               i;
        int               cap;
        logic [OWN_W-1:0] filler;
        cap = (own > NUM_BINS_DEF) ? NUM_BINS_DEF : own;
        if (count == 0) begin
            send_item(own, pick_neighbor(cap), 1'b0, 1'b1);
        end else begin
            for (i = 0; i < count; i++) begin
                filler = OWN_W'($urandom_range(0, (1 << OWN_W) - 1));
                send_item((i == 0) ? own : filler, pick_neighbor(cap),
                          $urandom_range(0, 9) != 0, i == count - 1);
            end
        end
    endtask

    initial begin
        int               i;
        int               roll;
        int               own;
        int               cap;
        logic [NB_W-1:0]  nb;

        // Reset is held first; the block then sweeps its histogram
        // and stalls the input until the sweep is done.
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Own estimate of zero: nothing is counted and the answer is zero.
        send_item(11'd0, 16'd5, 1'b1, 1'b1);
        send_item(11'd0, 16'd0, 1'b1, 1'b0);
        send_item(11'd0, 16'hFFFF, 1'b1, 1'b0);
        send_item(11'd0, 16'd1, 1'b1, 1'b1);
        // A vertex with no neighbors answers zero.
        send_item(11'd5, 16'd0, 1'b0, 1'b1);
        // Own estimate at the top of its field saturates to NUM_BINS; unknown,
        // huge and exact neighbors all land in the top bin, so the answer is 4.
        send_item(11'h7FF, 16'd0, 1'b1, 1'b0);
        send_item(11'd0, 16'hFFFF, 1'b1, 1'b0);
        send_item(11'd0, 16'd1024, 1'b1, 1'b0);
        send_item(11'd0, 16'd1024, 1'b1, 1'b1);
        // Smallest nonzero case.
        send_item(11'd1, 16'd1, 1'b1, 1'b1);
        // Clipped neighbors 3, 3, 2, 1 with an empty item in between: answer 2.
        send_item(11'd3, 16'd5, 1'b1, 1'b0);
        send_item(11'd3, 16'd0, 1'b1, 1'b0);
        send_item(11'd3, 16'd2, 1'b1, 1'b0);
        send_item(11'h7FF, 16'd7, 1'b0, 1'b0);
        send_item(11'd3, 16'd1, 1'b1, 1'b1);
        // Exactly NUM_BINS and one above it.
        send_item(11'd1024, 16'd1024, 1'b1, 1'b0);
        send_item(11'd1024, 16'd1023, 1'b1, 1'b1);
        send_item(11'd1025, 16'h8000, 1'b1, 1'b1);
        // The closing item of a run carries no neighbor.
        send_item(11'd4, 16'd4, 1'b1, 1'b0);
        send_item(11'd4, 16'd4, 1'b1, 1'b0);
        send_item(11'd4, 16'd0, 1'b0, 1'b1);

        // A long run whose neighbors all clip into the top bin of an own
        // estimate of two piles many counts into that one bin.
        for (i = 0; i < FLOOD_LEN; i++) begin
            roll = $urandom_range(0, 2);
            nb   = (roll == 0) ? 16'd0 : (roll == 1) ? 16'd2 :
                   NB_W'($urandom_range(2, 65535));
            send_item((i == 0) ? 11'd2 : OWN_W'($urandom_range(0, 2047)), nb, 1'b1,
                      i == FLOOD_LEN - 1);
        end

        // Random vertices. Most own estimates are small so that the neighbor
        // count straddles them and the scan stops at many different points; a
        // few are large or above NUM_BINS to exercise long scans and the
        // saturation of the own estimate.
        while (items_sent < ITEM_GOAL) begin
            calm        = (items_sent >= QUIET_FROM);
            sender_gaps = ($urandom_range(0, 3) != 0);
            roll        = $urandom_range(0, 19);
            if (roll == 0) begin
                own = 0;
            end else if (roll == 1) begin
                own = $urandom_range(NUM_BINS_DEF + 1, (1 << OWN_W) - 1);
            end else if (roll == 2) begin
                own = $urandom_range(41, NUM_BINS_DEF);
            end else begin
                own = $urandom_range(1, 40);
            end
            cap = (own > NUM_BINS_DEF) ? NUM_BINS_DEF : own;
            send_run(OWN_W'(own), $urandom_range(0, (cap + 4 < 40) ? cap + 4 : 40));
        end
        i_valid <= 1'b0;

        // Wait for every predicted result, then let any clearing pass finish.
        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("PASS capped_h_index_core_estimate");
        end else begin
            $display("FAIL capped_h_index_core_estimate");
        end
        $finish;
    end

endmodule
